### hw/rtl/rbc_pkg.sv
// Shared types, constants and helpers of the region boundary classifier.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rbc_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned XW        = 12;
  localparam int unsigned YW        = 10;
  localparam int unsigned WidthW    = 13;
  localparam int unsigned HeightW   = 11;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned MaxColLen = 1024;
  localparam int unsigned MaxCols   = 4096;
  localparam int unsigned AddrW     = $clog2(MaxColLen);
  localparam int unsigned NumRes    = 3;

  localparam logic [CfgIdxW-1:0] RegC0     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegC1     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegC2     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWidth  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd4;

  localparam logic [WidthW-1:0]  WidthReset  = 13'd640;
  localparam logic [HeightW-1:0] HeightReset = 11'd480;

  typedef enum logic [1:0] {
    ClsOut   = 2'd0,
    ClsEdge  = 2'd1,
    ClsInner = 2'd2
  } pix_class_e;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    pix_class_e    cls;
  } result_t;

  typedef struct packed {
    logic [NumRes-1:0]   mask;
    result_t [NumRes-1:0] res;
  } result_set_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          match;
    logic          last_row;
    logic          last_col;
    logic          prev_delayed;
    logic          delayed_ok;
    logic          inner_ok;
  } item_t;

  typedef struct packed {
    logic prev_bit;
    logic prev2_bit;
    logic wr_bank;
  } store_rd_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [AddrW-1:0] addr;
    logic             data;
  } store_wr_t;

  function automatic logic [WidthW-1:0] clamp_width(input logic [WidthW-1:0] v);
    logic [WidthW-1:0] r;
    r = v;
    if (v < WidthW'(2)) r = WidthW'(2);
    else if (v > WidthW'(MaxCols)) r = WidthW'(MaxCols);
    return r;
  endfunction

  function automatic logic [HeightW-1:0] clamp_height(input logic [HeightW-1:0] v);
    logic [HeightW-1:0] r;
    r = v;
    if (v < HeightW'(2)) r = HeightW'(2);
    else if (v > HeightW'(MaxColLen)) r = HeightW'(MaxColLen);
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rbc_col_store.sv
// Two single-bit column memories holding the match bits of the last two columns.
// Roles swap at each column end. Depends on rbc_pkg.
`default_nettype none

module rbc_col_store
  import rbc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  input  wire logic             swap_i,
  input  wire store_wr_t        wr_i,
  output store_rd_t             rd_o
);

  logic bank0_mem [MaxColLen];
  logic bank1_mem [MaxColLen];
  logic sel_q, sel_d;
  logic rd0_q, rd1_q, rd_sel_q;

  assign sel_d = sel_q ^ (rd_en_i & swap_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd0_q    <= bank0_mem[rd_addr_i];
      rd1_q    <= bank1_mem[rd_addr_i];
      rd_sel_q <= sel_q;
    end
    if (wr_i.en && !wr_i.bank) begin
      bank0_mem[wr_i.addr] <= wr_i.data;
    end
    if (wr_i.en && wr_i.bank) begin
      bank1_mem[wr_i.addr] <= wr_i.data;
    end
  end

  assign rd_o.prev_bit  = rd_sel_q ? rd1_q : rd0_q;
  assign rd_o.prev2_bit = rd_sel_q ? rd0_q : rd1_q;
  assign rd_o.wr_bank   = ~rd_sel_q;

endmodule

`default_nettype wire

### hw/rtl/rbc_classify.sv
// Classification of one registered pixel against its 3x3 neighborhood.
// Keeps the row window of the two previous columns. Depends on rbc_pkg.
`default_nettype none

module rbc_classify
  import rbc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      advance_i,
  input  wire item_t     item_i,
  input  wire store_rd_t rd_i,
  output result_set_t    set_o,
  output store_wr_t      wr_o
);

  logic p1_q, p2_q, q1_q, q2_q, b0_q, b1_q;
  logic all_match;
  pix_class_e delayed_cls;
  logic [XW-1:0] x_m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= 1'b0;
      p2_q <= 1'b0;
      q1_q <= 1'b0;
      q2_q <= 1'b0;
      b0_q <= 1'b0;
      b1_q <= 1'b0;
    end else if (advance_i) begin
      p1_q <= rd_i.prev_bit;
      p2_q <= p1_q;
      q1_q <= rd_i.prev2_bit;
      q2_q <= q1_q;
      b0_q <= item_i.last_row ? 1'b0 : item_i.match;
      b1_q <= item_i.last_row ? 1'b0 : b0_q;
    end
  end

  assign all_match = q2_q & q1_q & rd_i.prev2_bit & p2_q & p1_q & rd_i.prev_bit &
                     b1_q & b0_q & item_i.match;

  always_comb begin
    delayed_cls = ClsOut;
    if (p1_q) begin
      delayed_cls = (item_i.inner_ok && all_match) ? ClsInner : ClsEdge;
    end
  end

  assign x_m1 = item_i.x - XW'(1);

  assign set_o.mask[0]    = item_i.delayed_ok;
  assign set_o.res[0].x   = x_m1;
  assign set_o.res[0].y   = item_i.y - YW'(1);
  assign set_o.res[0].cls = delayed_cls;

  assign set_o.mask[1]    = item_i.prev_delayed & item_i.last_row;
  assign set_o.res[1].x   = x_m1;
  assign set_o.res[1].y   = item_i.y;
  assign set_o.res[1].cls = rd_i.prev_bit ? ClsEdge : ClsOut;

  assign set_o.mask[2]    = (item_i.x == '0) | item_i.last_col;
  assign set_o.res[2].x   = item_i.x;
  assign set_o.res[2].y   = item_i.y;
  assign set_o.res[2].cls = item_i.match ? ClsEdge : ClsOut;

  assign wr_o.en   = advance_i;
  assign wr_o.bank = rd_i.wr_bank;
  assign wr_o.addr = item_i.y;
  assign wr_o.data = item_i.match;

endmodule

`default_nettype wire

### hw/rtl/rbc_out_queue.sv
// Result register for the up to three results of one pixel, sent one per transfer.
// Depends on rbc_pkg.
`default_nettype none

module rbc_out_queue
  import rbc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire result_set_t set_i,
  input  wire logic        out_ready_i,
  output logic             free_o,
  output logic             out_valid_o,
  output result_t          out_res_o,
  output logic             out_last_o
);

  logic [NumRes-1:0] mask_q, mask_d, first_bit, rest;
  result_t [NumRes-1:0] res_q;

  always_comb begin
    priority if (mask_q[0]) begin
      first_bit = 3'b001;
      out_res_o = res_q[0];
    end else if (mask_q[1]) begin
      first_bit = 3'b010;
      out_res_o = res_q[1];
    end else begin
      first_bit = {mask_q[2], 2'b00};
      out_res_o = res_q[2];
    end
  end

  assign rest        = mask_q & ~first_bit;
  assign out_valid_o = |mask_q;
  assign out_last_o  = (rest == '0);
  assign free_o      = (mask_q == '0) | (out_last_o & out_ready_i);

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = set_i.mask;
    end else if (out_valid_o && out_ready_i) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= set_i.res;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/region_boundary_classify_top.sv
// Top level of the region boundary classifier: configuration registers, position
// counters and input register. Depends on rbc_pkg, rbc_col_store, rbc_classify and
// rbc_out_queue.
//
// Pixels enter on the s_axis channel in column-major order, one per transfer, each
// column image_height pixels long. Every pixel is reported once on m_axis with its
// coordinates and its class (outside, boundary, interior); tlast marks the last
// result caused by one input pixel, which may cause none, one, two or three.
// A pixel of an inner column is reported when the pixel one column right and one
// row down arrives, a bottom-row pixel when the one to its right arrives; pixels of
// the first and last column are reported at once. An input pixel is held in the
// input register, its results in the result register. One pixel is taken per cycle
// unless the receiver stalls; a pixel causing two or three results (only on the bottom
// row or in the last column) holds the input register, as results leave one per cycle.
// Reset clears the counters, the color to zero, the geometry to 640 by 480 and
// empties both stages; the column memories need no clearing. When the receiver
// stalls, the result register holds, the input register fills, and then tready
// drops. Configuration writes are meant for idle periods only.

`default_nettype none

module region_boundary_classify_top
  import rbc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [23:0]         s_axis_tdata_i,   // chan0, chan1, chan2
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [23:0]              m_axis_tdata_o,   // pixel_x, pixel_y, zero fill
  output logic [1:0]               m_axis_tuser_o,   // pixel_class
  output logic                     m_axis_tlast_o    // last_of_run
);

  logic [ChanW-1:0]   c0_q, c1_q, c2_q;
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [XW-1:0]      col_q, col_d;
  logic [YW-1:0]      row_q, row_d;
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;
  logic               accept, advance, out_free, a_valid_q;
  item_t              item_d, a_q;
  store_rd_t          rd;
  store_wr_t          wr;
  result_set_t        set;
  result_t            out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q     <= '0;
      c1_q     <= '0;
      c2_q     <= '0;
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegC0:     c0_q     <= cfg_data_i[ChanW-1:0];
        RegC1:     c1_q     <= cfg_data_i[ChanW-1:0];
        RegC2:     c2_q     <= cfg_data_i[ChanW-1:0];
        RegWidth:  width_q  <= cfg_data_i[WidthW-1:0];
        RegHeight: height_q <= cfg_data_i[HeightW-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = clamp_width(width_q);
  assign h_eff = clamp_height(height_q);

  assign advance         = a_valid_q & out_free;
  assign s_axis_tready_o = ~a_valid_q | out_free;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    item_d.x            = col_q;
    item_d.y            = row_q;
    item_d.match        = (s_axis_tdata_i[7:0] == c0_q) && (s_axis_tdata_i[15:8] == c1_q) &&
                          (s_axis_tdata_i[23:16] == c2_q);
    item_d.last_row     = {1'b0, row_q} >= (h_eff - HeightW'(1));
    item_d.last_col     = {1'b0, col_q} >= (w_eff - WidthW'(1));
    item_d.prev_delayed = (col_q >= XW'(2)) && ({1'b0, col_q} < w_eff);
    item_d.delayed_ok   = item_d.prev_delayed && (row_q != '0);
    item_d.inner_ok     = (row_q >= YW'(2)) && ({1'b0, row_q} < h_eff);
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (item_d.last_row) begin
        row_d = '0;
        col_d = item_d.last_col ? '0 : col_q + XW'(1);
      end else begin
        row_d = row_q + YW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      a_valid_q <= accept | (a_valid_q & ~advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= item_d;
    end
  end

  rbc_col_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (row_q),
    .swap_i    (item_d.last_row),
    .wr_i      (wr),
    .rd_o      (rd)
  );

  rbc_classify u_classify (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (a_q),
    .rd_i      (rd),
    .set_o     (set),
    .wr_o      (wr)
  );

  rbc_out_queue u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .set_i       (set),
    .out_ready_i (m_axis_tready_i),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid_o),
    .out_res_o   (out_res),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, out_res.y, out_res.x};
  assign m_axis_tuser_o = out_res.cls;

endmodule

`default_nettype wire

### hw/rtl/rbc_checker.sv
// Port-level checks for region_boundary_classify_top, attached by the bind below.
// Depends on rbc_pkg.
`default_nettype none

module rbc_checker
  import rbc_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  a_class_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == ClsOut || m_axis_tuser_o == ClsEdge ||
                         m_axis_tuser_o == ClsInner))
    else $error("Result carries an undefined class.");

  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=> m_axis_tvalid_o)
    else $error("Results of one pixel are not sent back to back.");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("Input stalled while no result is pending.");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("Output valid dropped without a transfer.");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      ($stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o)))
    else $error("Output payload changed while stalled.");

endmodule

bind region_boundary_classify_top rbc_checker u_rbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

### sim/pixel_class_checker.sv
// Checker of the region boundary classifier: watches the register port and both
// stream channels, predicts each pixel report and compares it with the transfer seen.
// Depends on rbc_pkg for widths, register indexes and the class encoding.
module pixel_class_checker
  import rbc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid_i,
  input  wire logic                s_axis_tready_i,
  input  wire logic [23:0]         s_axis_tdata_i,   // chan0, chan1, chan2
  input  wire logic                m_axis_tvalid_i,
  input  wire logic                m_axis_tready_i,
  input  wire logic [23:0]         m_axis_tdata_i,   // pixel_x, pixel_y, zero fill
  input  wire logic [1:0]          m_axis_tuser_i,   // pixel_class
  input  wire logic                m_axis_tlast_i,   // last_of_run
  output int                       mismatch_count_o,
  output int                       reports_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    pix_class_e    cls;
  } pixel_report_t;

  logic [ChanW-1:0]   key_color [3];
  logic [WidthW-1:0]  width_reg;
  logic [HeightW-1:0] height_reg;
  bit                 match_col [2][MaxColLen];
  bit                 prev_bank;
  logic [1:0]         recent_bits;
  logic [XW-1:0]      col_pos;
  logic [YW-1:0]      row_pos;
  pixel_report_t      reports_q [$];
  bit                 run_end_q [$];
  int                 mismatches;

  function automatic void note_report(input int x, input int y, input pix_class_e cls);
    pixel_report_t rep;
    rep.x = XW'(x);
    rep.y = YW'(y);
    rep.cls = cls;
    reports_q.insert(reports_q.size(), rep);
    run_end_q.insert(run_end_q.size(), 1'b0);
  endfunction

  function automatic void classify_pixel(input logic [23:0] px);
    int w, h, x, y, cy, r, n0;
    bit m, last_row, last_col, delayed, b0, b1, all_in, p, q;
    pix_class_e cls;
    n0 = run_end_q.size();
    w = int'(width_reg);
    if (w < 2) begin
      w = 2;
    end else if (w > int'(MaxCols)) begin
      w = MaxCols;
    end
    h = int'(height_reg);
    if (h < 2) begin
      h = 2;
    end else if (h > int'(MaxColLen)) begin
      h = MaxColLen;
    end
    x = int'(col_pos);
    y = int'(row_pos);
    m = (px[7:0] == key_color[0]) && (px[15:8] == key_color[1]) &&
        (px[23:16] == key_color[2]);
    last_row = (y >= h - 1);
    last_col = (x >= w - 1);
    delayed = (x >= 2) && (x < w);
    b1 = recent_bits[1];
    b0 = recent_bits[0];
    p = prev_bank;
    q = !prev_bank;

    if (delayed && y >= 1) begin
      cy = y - 1;
      cls = ClsOut;
      if (match_col[p][cy]) begin
        cls = ClsEdge;
        if (cy >= 1 && cy < h - 1) begin
          all_in = b1 & b0 & m;
          for (r = y - 2; r <= y; r++) begin
            all_in = all_in & match_col[q][r] & match_col[p][r];
          end
          if (all_in) begin
            cls = ClsInner;
          end
        end
      end
      note_report(x - 1, cy, cls);
    end
    if (delayed && last_row) begin
      note_report(x - 1, y, match_col[p][y] ? ClsEdge : ClsOut);
    end
    if (x == 0 || last_col) begin
      note_report(x, y, m ? ClsEdge : ClsOut);
    end

    // The column two back is dead above row y-1, so the current column goes there.
    if (y >= 2) begin
      match_col[q][y-2] = b1;
    end
    recent_bits = {recent_bits[0], m};
    if (last_row) begin
      if (y >= 1) begin
        match_col[q][y-1] = b0;
      end
      match_col[q][y] = m;
      prev_bank = q;
      recent_bits = '0;
      row_pos = '0;
      col_pos = last_col ? '0 : XW'(x + 1);
    end else begin
      row_pos = YW'(y + 1);
    end

    if (run_end_q.size() > n0) begin
      run_end_q[run_end_q.size()-1] = 1'b1;
    end
  endfunction

  function automatic void check_result(input logic [XW-1:0] gx, input logic [YW-1:0] gy,
                                       input logic [1:0] gc, input logic gl);
    int i, k;
    pixel_report_t want;
    bit want_last;
    if (reports_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result x=%0d y=%0d class=%0d last=%0d",
               $time, gx, gy, gc, gl);
      return;
    end
    // Reports are matched on coordinates, the run end flag by position.
    k = -1;
    for (i = 0; i < reports_q.size() && k < 0; i++) begin
      if (reports_q[i].x == gx && reports_q[i].y == gy) begin
        k = i;
      end
    end
    if (k < 0) begin
      k = 0;
    end
    want = reports_q[k];
    reports_q.delete(k);
    want_last = run_end_q.pop_front();
    if (want.x !== gx || want.y !== gy || 2'(want.cls) !== gc || want_last !== gl) begin
      mismatches++;
      $display("%0t: mismatch: expected x=%0d y=%0d class=%0d last=%0d,",
               $time, want.x, want.y, want.cls, want_last);
      $display("    actual x=%0d y=%0d class=%0d last=%0d", gx, gy, gc, gl);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_color[0] = '0;
      key_color[1] = '0;
      key_color[2] = '0;
      width_reg = WidthReset;
      height_reg = HeightReset;
      prev_bank = 1'b0;
      recent_bits = '0;
      col_pos = '0;
      row_pos = '0;
      reports_q.delete();
      run_end_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      reports_due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegC0: key_color[0] = cfg_data_i[ChanW-1:0];
          RegC1: key_color[1] = cfg_data_i[ChanW-1:0];
          RegC2: key_color[2] = cfg_data_i[ChanW-1:0];
          RegWidth: width_reg = cfg_data_i[WidthW-1:0];
          RegHeight: height_reg = cfg_data_i[HeightW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        classify_pixel(s_axis_tdata_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_result(m_axis_tdata_i[XW-1:0], m_axis_tdata_i[XW+YW-1:XW],
                     m_axis_tuser_i, m_axis_tlast_i);
      end
      mismatch_count_o <= mismatches;
      reports_due_o <= reports_q.size();
    end
  end

endmodule

### sim/tb_region_boundary_classify_top.sv
// Testbench top of the region boundary classifier: clock, reset, register writes,
// pixel frames and receiver back-pressure; the verdict comes from pixel_class_checker.
// Depends on rbc_pkg, region_boundary_classify_top and pixel_class_checker.
module tb_region_boundary_classify_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rbc_pkg::*;

  localparam int HalfPeriod  = 6;
  localparam int ResetCycles = 3;
  localparam int DrainCycles = 16;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 400000;
  localparam int IdlePct     = 12;
  localparam int RandomItems = 240;
  localparam logic [CfgIdxW-1:0] RegUnused = RegHeight + CfgIdxW'(1);

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_valid = 1'b0;
  logic [23:0]         s_data = '0;
  logic                s_ready;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [23:0]         m_data;
  logic [1:0]          m_user;
  logic                m_last;
  int                  mismatch_count;
  int                  reports_due;

  bit         src_idle_on = 1'b1;
  bit         snk_idle_on = 1'b1;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  int         cycle_cnt = 0;
  logic [7:0] stim_color [3];

  region_boundary_classify_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  pixel_class_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .s_axis_tvalid_i  (s_valid),
    .s_axis_tready_i  (s_ready),
    .s_axis_tdata_i   (s_data),
    .m_axis_tvalid_i  (m_valid),
    .m_axis_tready_i  (m_ready),
    .m_axis_tdata_i   (m_data),
    .m_axis_tuser_i   (m_user),
    .m_axis_tlast_i   (m_last),
    .mismatch_count_o (mismatch_count),
    .reports_due_o    (reports_due)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (snk_idle_on) begin
        m_ready <= ($urandom_range(99) >= IdlePct);
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  function automatic int eff_dim(input int raw, input int hi);
    if (raw < 2) begin
      return 2;
    end
    return (raw > hi) ? hi : raw;
  endfunction

  function automatic logic [23:0] make_pixel(input int match_pct);
    logic [23:0] px;
    px = {stim_color[2], stim_color[1], stim_color[0]};
    if ($urandom_range(99) >= match_pct) begin
      if ($urandom_range(1) == 1) begin
        px = px ^ (24'd1 << (8 * $urandom_range(2) + $urandom_range(7)));
      end else begin
        px = 24'($urandom);
      end
    end
    return px;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CfgDataW'(val);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_color(input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
    stim_color[0] = c0;
    stim_color[1] = c1;
    stim_color[2] = c2;
    write_reg(RegC0, int'(c0) | (int'($urandom_range(31)) << ChanW));
    write_reg(RegC1, int'(c1) | (int'($urandom_range(31)) << ChanW));
    write_reg(RegC2, int'(c2) | (int'($urandom_range(31)) << ChanW));
  endtask

  task automatic send_pixel(input logic [23:0] px);
    while (src_idle_on && $urandom_range(99) < IdlePct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= px;
    do @(posedge clk_i); while (!s_ready);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (reports_due != 0);
  endtask

  task automatic settle();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_run(input int count, input int match_pct, input int hold_at,
                          input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) begin
        hold_req = 1'b1;
      end
      if (i == pause_at) begin
        wait_drained();
      end
      send_pixel(make_pixel(match_pct));
    end
  endtask

  function automatic logic [7:0] pick_channel();
    int r;
    r = $urandom_range(9);
    if (r < 2) begin
      return 8'h00;
    end else if (r < 4) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  initial begin
    int sent, frames, raw_w, raw_h, count, hold_at, pause_at;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A fully matching 3x3 frame: its center pixel is the only interior one.
    set_color(8'hFF, 8'h00, 8'hFF);
    write_reg(RegWidth, 3);
    write_reg(RegHeight, 3);
    send_run(9, 100, -1, -1);
    settle();

    // Height lowered in the middle of an inner column ends that column early.
    set_color(8'h00, 8'h00, 8'h00);
    write_reg(RegWidth, 4);
    write_reg(RegHeight, 4);
    send_pixel(24'hFFFFFF);
    send_run(9, 75, -1, -1);
    settle();
    write_reg(RegHeight, 2);
    send_run(3, 75, -1, -1);
    settle();

    // Width lowered mid-frame makes the next column the last one.
    set_color(pick_channel(), pick_channel(), pick_channel());
    write_reg(RegWidth, 5);
    write_reg(RegHeight, 2);
    send_run(6, 85, -1, -1);
    settle();
    write_reg(RegWidth, 2);
    send_run(2, 85, -1, -1);
    settle();

    sent = 0;
    frames = 0;
    while (sent < RandomItems) begin
      case ($urandom_range(9))
        0: raw_w = $urandom_range(1);
        1, 2: raw_w = $urandom_range(9, 24);
        default: raw_w = $urandom_range(2, 8);
      endcase
      case ($urandom_range(9))
        0: raw_h = $urandom_range(1);
        1: raw_h = $urandom_range(9, 12);
        default: raw_h = $urandom_range(2, 8);
      endcase
      set_color(pick_channel(), pick_channel(), pick_channel());
      if ($urandom_range(3) == 0) begin
        write_reg(RegUnused + CfgIdxW'($urandom_range(2)), int'($urandom));
      end
      write_reg(RegWidth, raw_w);
      write_reg(RegHeight, raw_h);
      count = eff_dim(raw_w, MaxCols) * eff_dim(raw_h, MaxColLen);
      hold_at = -1;
      pause_at = -1;
      if (frames == 0) begin
        hold_at = 0;
      end else if ($urandom_range(5) == 0) begin
        hold_at = $urandom_range(count - 1);
      end
      if (frames == 1 || $urandom_range(4) == 0) begin
        pause_at = $urandom_range(1, count - 1);
      end
      send_run(count, $urandom_range(30, 95), hold_at, pause_at);
      settle();
      sent += count;
      frames++;
    end

    // Width and height written out of range; after three columns the width is lowered so the fourth is the last.
    set_color(pick_channel(), pick_channel(), pick_channel());
    write_reg(RegWidth, 8191);
    write_reg(RegHeight, 0);
    send_run(6, 80, -1, -1);
    settle();
    write_reg(RegWidth, 2);
    send_run(2, 80, -1, -1);
    settle();

    // Height written above the memory depth; the first column is cut short later.
    set_color(pick_channel(), pick_channel(), pick_channel());
    write_reg(RegWidth, 1);
    write_reg(RegHeight, 2047);
    send_run(12, 80, -1, -1);
    settle();
    write_reg(RegHeight, 0);
    send_run(3, 80, -1, -1);
    settle();

    // A larger frame run with no idling on either side.
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    set_color(pick_channel(), pick_channel(), pick_channel());
    write_reg(RegWidth, 12);
    write_reg(RegHeight, 10);
    send_run(120, 85, -1, -1);
    settle();

    if (mismatch_count == 0 && reports_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/rbc_pkg.sv
hw/rtl/rbc_col_store.sv
hw/rtl/rbc_classify.sv
hw/rtl/rbc_out_queue.sv
hw/rtl/region_boundary_classify_top.sv
hw/rtl/rbc_checker.sv
sim/pixel_class_checker.sv
sim/tb_region_boundary_classify_top.sv
